>>> rtl/core/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants for the single-wire sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

	// register widths
	localparam int START_W   = 18;
	localparam int SHORT_W   = 8;
	localparam int TMO_W     = 16;
	localparam int NBYTES_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = START_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_LOW_TMO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_HI_TMO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_WAIT_TMO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES        = 3'd6;

	// register reset values
	localparam logic [START_W-1:0]  RST_START_LOW    = 18'd20000;
	localparam logic [SHORT_W-1:0]  RST_RELEASE_WAIT = 8'd30;
	localparam logic [SHORT_W-1:0]  RST_SAMPLE_DELAY = 8'd30;
	localparam logic [TMO_W-1:0]    RST_RESP_LOW_TMO = 16'd500;
	localparam logic [TMO_W-1:0]    RST_RESP_HI_TMO  = 16'd800;
	localparam logic [TMO_W-1:0]    RST_BIT_WAIT_TMO = 16'd50000;
	localparam logic [NBYTES_W-1:0] RST_BYTES        = 4'd5;

	// sequencer phases
	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
	localparam logic [PH_W-1:0] PH_START     = 3'd1;
	localparam logic [PH_W-1:0] PH_RELEASE   = 3'd2;
	localparam logic [PH_W-1:0] PH_RESP_LOW  = 3'd3;
	localparam logic [PH_W-1:0] PH_RESP_HIGH = 3'd4;
	localparam logic [PH_W-1:0] PH_BIT_LOW   = 3'd5;
	localparam logic [PH_W-1:0] PH_SAMPLE    = 3'd6;
	localparam logic [PH_W-1:0] PH_BIT_HIGH  = 3'd7;

	typedef struct packed {
		logic [START_W-1:0]  start_low_ticks;
		logic [SHORT_W-1:0]  release_wait_ticks;
		logic [SHORT_W-1:0]  sample_delay_ticks;
		logic [TMO_W-1:0]    response_low_timeout;
		logic [TMO_W-1:0]    response_high_timeout;
		logic [TMO_W-1:0]    bit_wait_timeout;
		logic [NBYTES_W-1:0] bytes_per_read;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       answered;
		logic       error;
		logic       busy_res;
	} res_t;

endpackage

>>> rtl/core/swsr_cfg.sv
// ----------------------------------------------------------------------------
// swsr_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module swsr_cfg
	import swsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks       <= RST_START_LOW;
			cfg_q.release_wait_ticks    <= RST_RELEASE_WAIT;
			cfg_q.sample_delay_ticks    <= RST_SAMPLE_DELAY;
			cfg_q.response_low_timeout  <= RST_RESP_LOW_TMO;
			cfg_q.response_high_timeout <= RST_RESP_HI_TMO;
			cfg_q.bit_wait_timeout      <= RST_BIT_WAIT_TMO;
			cfg_q.bytes_per_read        <= RST_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LOW:    cfg_q.start_low_ticks       <= cfg_data[START_W-1:0];
				REG_RELEASE_WAIT: cfg_q.release_wait_ticks    <= cfg_data[SHORT_W-1:0];
				REG_SAMPLE_DELAY: cfg_q.sample_delay_ticks    <= cfg_data[SHORT_W-1:0];
				REG_RESP_LOW_TMO: cfg_q.response_low_timeout  <= cfg_data[TMO_W-1:0];
				REG_RESP_HI_TMO:  cfg_q.response_high_timeout <= cfg_data[TMO_W-1:0];
				REG_BIT_WAIT_TMO: cfg_q.bit_wait_timeout      <= cfg_data[TMO_W-1:0];
				REG_BYTES:        cfg_q.bytes_per_read        <= cfg_data[NBYTES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/swsr_core.sv
// ----------------------------------------------------------------------------
// swsr_core
// Read sequencer: phase, tick counter, bit/byte counters, shifter and flags.
// ----------------------------------------------------------------------------
module swsr_core
	import swsr_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic command,
	input  logic line_level,
	input  cfg_t cfg,
	output res_t res
);

	localparam int LW = (TICK_COUNT_WIDTH > START_W) ? TICK_COUNT_WIDTH : START_W;
	localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX = {TICK_COUNT_WIDTH{1'b1}};

	logic [PH_W-1:0]             phase_q, phase_n;
	logic [TICK_COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt_inc;
	logic [2:0]                  bit_q, bit_n;
	logic [2:0]                  byte_q, byte_n;
	logic [7:0]                  shift_q, shift_n;
	logic                        ans_q, ans_n;
	logic                        err_q, err_n;

	logic [LW-1:0]       lim_raw, lim;
	logic                reached;
	logic [NBYTES_W-1:0] nbytes;
	logic                last;
	logic                valid;
	logic [7:0]          byte_out;

	// saturating tick count
	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		case (phase_q)
			PH_START:     lim_raw = LW'(cfg.start_low_ticks);
			PH_RELEASE:   lim_raw = LW'(cfg.release_wait_ticks);
			PH_RESP_LOW:  lim_raw = LW'(cfg.response_low_timeout);
			PH_RESP_HIGH: lim_raw = LW'(cfg.response_high_timeout);
			PH_SAMPLE:    lim_raw = LW'(cfg.sample_delay_ticks);
			default:      lim_raw = LW'(cfg.bit_wait_timeout);
		endcase
	end

	assign lim     = (lim_raw > LW'(CNT_MAX)) ? LW'(CNT_MAX) : lim_raw;
	assign reached = LW'(cnt_inc) >= lim;

	always_comb begin
		if (cfg.bytes_per_read == '0)
			nbytes = NBYTES_W'(1);
		else if (cfg.bytes_per_read > NBYTES_W'(8))
			nbytes = NBYTES_W'(8);
		else
			nbytes = cfg.bytes_per_read;
	end

	assign last = (NBYTES_W'(byte_q) + 1'b1) >= nbytes;

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_inc;
		bit_n    = bit_q;
		byte_n   = byte_q;
		shift_n  = shift_q;
		ans_n    = ans_q;
		err_n    = err_q;
		valid    = 1'b0;
		byte_out = '0;
		if (command) begin
			ans_n   = 1'b0;
			err_n   = 1'b0;
			bit_n   = '0;
			byte_n  = '0;
			shift_n = '0;
			phase_n = PH_START;
			cnt_n   = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					cnt_n = cnt_q;
				end
				PH_START: begin
					if (reached) begin
						phase_n = PH_RELEASE;
						cnt_n   = '0;
					end
				end
				PH_RELEASE: begin
					if (reached) begin
						cnt_n = '0;
						if (!line_level) begin
							ans_n   = 1'b1;
							phase_n = PH_RESP_LOW;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
				PH_RESP_LOW: begin
					if (line_level || reached) begin
						err_n   = err_q | ~line_level;
						phase_n = PH_RESP_HIGH;
						cnt_n   = '0;
					end
				end
				PH_RESP_HIGH: begin
					if (!line_level || reached) begin
						err_n   = err_q | line_level;
						phase_n = PH_BIT_LOW;
						cnt_n   = '0;
					end
				end
				PH_BIT_LOW: begin
					if (line_level || reached) begin
						phase_n = PH_SAMPLE;
						cnt_n   = '0;
					end
				end
				PH_SAMPLE: begin
					if (reached) begin
						shift_n = {shift_q[6:0], line_level};
						phase_n = PH_BIT_HIGH;
						cnt_n   = '0;
					end
				end
				PH_BIT_HIGH: begin
					if (!line_level || reached) begin
						cnt_n = '0;
						if (bit_q == 3'd7) begin
							valid    = 1'b1;
							byte_out = shift_q;
							bit_n    = '0;
							shift_n  = '0;
							if (last) begin
								byte_n  = '0;
								phase_n = PH_IDLE;
							end else begin
								byte_n  = byte_q + 1'b1;
								phase_n = PH_BIT_LOW;
							end
						end else begin
							bit_n   = bit_q + 1'b1;
							phase_n = PH_BIT_LOW;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
					cnt_n   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			ans_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			ans_q   <= ans_n;
			err_q   <= err_n;
		end
	end

	always_comb begin
		res.drive_low  = (phase_n == PH_START);
		res.data_byte  = byte_out;
		res.byte_valid = valid;
		res.last_byte  = valid & last;
		res.answered   = ans_n;
		res.error      = err_n;
		res.busy_res   = (phase_n != PH_IDLE);
	end

endmodule

>>> rtl/core/single_wire_sensor_reader.sv
// Path: each input transfer passes the input register, then the result register, and is
// then valid on m_*; stage 1 waits while the result register is full and not draining.
// Throughput: one tick per cycle unless the output stalls, set by the sequencer's
// combinational next-state logic between the input register and the result register.
// Reset (arst_n low): sequencer idle, counters and flags cleared, registers take
// their defaults, both stream stages empty.
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Master side of a single-wire humidity sensor read, one input per 1 us tick.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader
	import swsr_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] line_level, [7:1] zero
	input  logic                  s_tuser,   // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [0] drive_low, [8:1] data_byte,
	                                         // [9] answered, [10] error, [11] busy_res
	output logic                  m_tuser,   // [0] byte_valid
	output logic                  m_tlast    // last_byte
);

	cfg_t cfg;
	res_t res;

	logic valid_s1, cmd_s1, line_s1;
	logic valid_s2;
	res_t res_s2;
	logic advance;

	// stage 1 moves into the result register when that register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	swsr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swsr_core #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.command    (cmd_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			line_s1 <= s_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.busy_res, res_s2.error, res_s2.answered,
		res_s2.data_byte, res_s2.drive_low};
	assign m_tuser  = res_s2.byte_valid;
	assign m_tlast  = res_s2.last_byte;

endmodule

>>> sim/single_wire_sensor_reader_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_test
// Self-checking bench for the single-wire sensor reader. Sensor line waveforms
// (well-formed reads with random timing and data, aborted reads, noise) are
// sent as ticks on the input stream; a tick-level model of the read sequencer
// predicts every result, which is checked field by field against the output
// stream. Both sides idle at random, and the output side holds off once for a
// long stretch. The registers are rewritten between phases: defaults, all
// zero, all one, random small timings, out-of-range byte count, all maximum.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_test;
	import swsr_pkg::*;

	localparam int unsigned TICK_MAX  = (1 << 18) - 1;
	localparam int unsigned CYCLE_CAP = 400000;

	typedef struct packed {
		bit cmd;
		bit line;
	} tick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [0] line_level, [7:1] zero
	logic                  s_tuser;   // [0] command
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [0] drive_low, [8:1] data_byte,
	                                  // [9] answered, [10] error, [11] busy_res
	logic                  m_tuser;   // [0] byte_valid
	logic                  m_tlast;   // last_byte

	single_wire_sensor_reader dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// pending ticks and expected results
	tick_t       tick_q[$];
	res_t        want_q[$];
	int unsigned built;
	int unsigned results;
	int unsigned mismatches;
	int unsigned cycles;

	// read sequencer model
	cfg_t           rd_cfg;
	logic [PH_W-1:0] seq_ph;
	int unsigned    tick_cnt;
	logic [2:0]     bit_pos;
	logic [2:0]     byte_pos;
	logic [7:0]     shreg;
	bit             ans_flag;
	bit             err_flag;

	// stream side state
	bit          in_fire, out_fire;
	bit          tx_steady, rx_steady, held_off;
	int unsigned tx_gap, rx_gap, rx_hold;
	tick_t       nxt;
	res_t        seen;

	function automatic int unsigned at_least_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic void go(input logic [PH_W-1:0] ph);
		seq_ph   = ph;
		tick_cnt = 0;
	endfunction

	// saturating tick count, true once the limit is reached
	function automatic bit count_up(input int unsigned lim);
		int unsigned cap;
		cap = (lim > TICK_MAX) ? TICK_MAX : lim;
		if (tick_cnt < TICK_MAX)
			tick_cnt++;
		return tick_cnt >= cap;
	endfunction

	function automatic res_t sensor_step(input bit cmd, input bit line);
		res_t        r;
		int unsigned nbytes;
		bit          done;
		r = '0;
		nbytes = (rd_cfg.bytes_per_read == 0) ? 1 :
			((rd_cfg.bytes_per_read > 8) ? 8 : rd_cfg.bytes_per_read);
		if (cmd) begin
			ans_flag = 0;
			err_flag = 0;
			bit_pos  = 0;
			byte_pos = 0;
			shreg    = 0;
			go(PH_START);
		end else begin
			case (seq_ph)
				PH_START: begin
					if (count_up(rd_cfg.start_low_ticks))
						go(PH_RELEASE);
				end
				PH_RELEASE: begin
					if (count_up(rd_cfg.release_wait_ticks)) begin
						if (!line) begin
							ans_flag = 1;
							go(PH_RESP_LOW);
						end else begin
							go(PH_IDLE);
						end
					end
				end
				PH_RESP_LOW: begin
					if (line) begin
						go(PH_RESP_HIGH);
					end else if (count_up(rd_cfg.response_low_timeout)) begin
						err_flag = 1;
						go(PH_RESP_HIGH);
					end
				end
				PH_RESP_HIGH: begin
					if (!line) begin
						go(PH_BIT_LOW);
					end else if (count_up(rd_cfg.response_high_timeout)) begin
						err_flag = 1;
						go(PH_BIT_LOW);
					end
				end
				PH_BIT_LOW: begin
					if (line)
						go(PH_SAMPLE);
					else if (count_up(rd_cfg.bit_wait_timeout))
						go(PH_SAMPLE);
				end
				PH_SAMPLE: begin
					if (count_up(rd_cfg.sample_delay_ticks)) begin
						shreg = {shreg[6:0], line};
						go(PH_BIT_HIGH);
					end
				end
				PH_BIT_HIGH: begin
					// the timeout count only advances while the line stays high
					done = !line;
					if (!done)
						done = count_up(rd_cfg.bit_wait_timeout);
					if (done) begin
						if (bit_pos == 3'd7) begin
							r.byte_valid = 1;
							r.data_byte  = shreg;
							r.last_byte  = (byte_pos + 1 >= nbytes);
							bit_pos = 0;
							shreg   = 0;
							if (r.last_byte) begin
								byte_pos = 0;
								go(PH_IDLE);
							end else begin
								byte_pos++;
								go(PH_BIT_LOW);
							end
						end else begin
							bit_pos++;
							go(PH_BIT_LOW);
						end
					end
				end
				default: go(PH_IDLE);
			endcase
		end
		r.drive_low = (seq_ph == PH_START);
		r.answered  = ans_flag;
		r.error     = err_flag;
		r.busy_res  = (seq_ph != PH_IDLE);
		return r;
	endfunction

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// ---------------- stimulus ----------------

	task automatic add_item(input bit cmd, input bit line);
		tick_q.push_back('{cmd: cmd, line: line});
		built++;
	endtask

	task automatic add_level(input bit line, input int unsigned n);
		repeat (n) add_item(1'b0, line);
	endtask

	// one sensor conversation; now and then cut short so the next start abandons it
	task automatic queue_conversation();
		int unsigned nb, s, cut, mark;
		mark = built;
		nb = (rd_cfg.bytes_per_read == 0) ? 1 :
			((rd_cfg.bytes_per_read > 8) ? 8 : rd_cfg.bytes_per_read);
		s   = at_least_one(rd_cfg.sample_delay_ticks);
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : 0;
		add_item(1'b1, 1'($urandom));
		// line level is a don't-care while the start pulse is driven
		repeat (at_least_one(rd_cfg.start_low_ticks)) add_item(1'b0, 1'($urandom));
		add_level(1'b1, at_least_one(rd_cfg.release_wait_ticks) - 1);
		if ($urandom_range(0, 9) == 0) begin
			add_level(1'b1, $urandom_range(1, 4));   // sensor silent
		end else begin
			add_level(1'b0, $urandom_range(1, at_least_one(rd_cfg.response_low_timeout) + 2));
			add_level(1'b1, $urandom_range(1, at_least_one(rd_cfg.response_high_timeout) + 2));
			repeat (nb) begin
				repeat (8) begin
					add_level(1'b0, ($urandom_range(0, 19) == 0) ?
						at_least_one(rd_cfg.bit_wait_timeout) + 1 : $urandom_range(1, 3));
					add_level(1'b1, $urandom_range(0, 1) ?
						s + $urandom_range(1, 3) : $urandom_range(1, s));
				end
			end
			add_level(1'b1, $urandom_range(1, 4));
		end
		if (cut != 0) begin
			while (built > mark + cut) begin
				void'(tick_q.pop_back());
				built--;
			end
		end
	endtask

	task automatic run_reads(input int unsigned budget);
		int unsigned mark;
		mark = built;
		while (built - mark < budget) begin
			if ($urandom_range(0, 4) != 0) begin
				queue_conversation();
			end else begin
				repeat ($urandom_range(3, 15))
					add_item($urandom_range(0, 15) == 0, 1'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_START_LOW:    rd_cfg.start_low_ticks       = val[START_W-1:0];
			REG_RELEASE_WAIT: rd_cfg.release_wait_ticks    = val[SHORT_W-1:0];
			REG_SAMPLE_DELAY: rd_cfg.sample_delay_ticks    = val[SHORT_W-1:0];
			REG_RESP_LOW_TMO: rd_cfg.response_low_timeout  = val[TMO_W-1:0];
			REG_RESP_HI_TMO:  rd_cfg.response_high_timeout = val[TMO_W-1:0];
			REG_BIT_WAIT_TMO: rd_cfg.bit_wait_timeout      = val[TMO_W-1:0];
			REG_BYTES:        rd_cfg.bytes_per_read        = val[NBYTES_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input cfg_t c);
		write_reg(REG_START_LOW,    CFG_DATA_W'(c.start_low_ticks));
		write_reg(REG_RELEASE_WAIT, CFG_DATA_W'(c.release_wait_ticks));
		write_reg(REG_SAMPLE_DELAY, CFG_DATA_W'(c.sample_delay_ticks));
		write_reg(REG_RESP_LOW_TMO, CFG_DATA_W'(c.response_low_timeout));
		write_reg(REG_RESP_HI_TMO,  CFG_DATA_W'(c.response_high_timeout));
		write_reg(REG_BIT_WAIT_TMO, CFG_DATA_W'(c.bit_wait_timeout));
		write_reg(REG_BYTES,        CFG_DATA_W'(c.bytes_per_read));
	endtask

	function automatic cfg_t small_cfg(input int unsigned nb_lo, input int unsigned nb_hi);
		cfg_t c;
		c.start_low_ticks       = START_W'($urandom_range(1, 12));
		c.release_wait_ticks    = SHORT_W'($urandom_range(1, 8));
		c.sample_delay_ticks    = SHORT_W'($urandom_range(1, 6));
		c.response_low_timeout  = TMO_W'($urandom_range(1, 20));
		c.response_high_timeout = TMO_W'($urandom_range(1, 20));
		c.bit_wait_timeout      = TMO_W'($urandom_range(2, 16));
		c.bytes_per_read        = NBYTES_W'($urandom_range(nb_lo, nb_hi));
		return c;
	endfunction

	// every queued tick sent and every result back, then let the pipe empty
	task automatic settle();
		while (tick_q.size() != 0 || s_tvalid || want_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------- clock, reset, sequence ----------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cfg_t c;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		rd_cfg = '{RST_START_LOW, RST_RELEASE_WAIT, RST_SAMPLE_DELAY, RST_RESP_LOW_TMO,
			RST_RESP_HI_TMO, RST_BIT_WAIT_TMO, RST_BYTES};
		seq_ph   = PH_IDLE;
		tick_cnt = 0;
		bit_pos  = 0;
		byte_pos = 0;
		shreg    = 0;
		ans_flag = 0;
		err_flag = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: idle ticks at both levels, then a start abandoned by another
		add_item(1'b0, 1'b0);
		add_item(1'b0, 1'b1);
		add_item(1'b1, 1'b0);
		add_item(1'b0, 1'b1);
		add_item(1'b0, 1'b0);
		add_item(1'b1, 1'b1);
		add_item(1'b0, 1'b0);
		settle();

		// zero limits behave as one, zero byte count as one byte
		set_config('0);
		add_item(1'b1, 1'b1);
		add_item(1'b0, 1'b0);
		add_item(1'b0, 1'b1);   // no answer
		add_item(1'b0, 1'b0);   // idle tick
		add_item(1'b1, 1'b0);
		add_item(1'b0, 1'b1);
		add_item(1'b0, 1'b0);   // answer
		add_item(1'b0, 1'b0);   // response low timeout
		add_item(1'b0, 1'b1);   // response high timeout
		run_reads(40);
		settle();

		c = '{START_W'(1), SHORT_W'(1), SHORT_W'(1), TMO_W'(1), TMO_W'(1), TMO_W'(1),
			NBYTES_W'(1)};
		set_config(c);
		run_reads(30);
		settle();

		set_config(small_cfg(1, 6));
		run_reads(60);
		settle();

		// byte count above eight reads eight
		c = small_cfg(15, 15);
		c.sample_delay_ticks = 1;
		set_config(c);
		run_reads(100);
		settle();

		c = '{START_W'(262143), SHORT_W'(255), SHORT_W'(255), TMO_W'(65535), TMO_W'(65535),
			TMO_W'(65535), NBYTES_W'(8)};
		set_config(c);
		add_item(1'b1, 1'b0);
		repeat (20) add_item(1'b0, 1'($urandom));
		add_item(1'b1, 1'b1);
		repeat (15) add_item(1'b0, 1'($urandom));
		settle();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- input side ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				in_fire = 0;
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					nxt = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.cmd;
					s_tdata  <= {7'd0, nxt.line};
					if ($urandom_range(0, 39) == 0)
						tx_steady = !tx_steady;
					tx_gap = tx_steady ? 0 : $urandom_range(0, 14);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- output side ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				out_fire = 0;
				if ($urandom_range(0, 39) == 0)
					rx_steady = !rx_steady;
				rx_gap = rx_steady ? 0 : $urandom_range(0, 14);
			end
			// one long hold-off so the block backs up into its input
			if (!held_off && results >= 200) begin
				held_off = 1;
				rx_hold  = 300;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want_q.push_back(sensor_step(s_tuser, s_tdata[0]));
				in_fire = 1;
			end
			if (m_tvalid && m_tready) begin
				out_fire = 1;
				results++;
				seen.drive_low  = m_tdata[0];
				seen.data_byte  = m_tdata[8:1];
				seen.byte_valid = m_tuser;
				seen.last_byte  = m_tlast;
				seen.answered   = m_tdata[9];
				seen.error      = m_tdata[10];
				seen.busy_res   = m_tdata[11];
				if (want_q.size() == 0) begin
					report("result with none expected", m_tdata, 0);
				end else begin
					res_t want;
					want = want_q.pop_front();
					if (seen.drive_low !== want.drive_low)
						report("drive_low", seen.drive_low, want.drive_low);
					if (seen.data_byte !== want.data_byte)
						report("data_byte", seen.data_byte, want.data_byte);
					if (seen.byte_valid !== want.byte_valid)
						report("byte_valid", seen.byte_valid, want.byte_valid);
					if (seen.last_byte !== want.last_byte)
						report("last_byte", seen.last_byte, want.last_byte);
					if (seen.answered !== want.answered)
						report("answered", seen.answered, want.answered);
					if (seen.error !== want.error)
						report("error", seen.error, want.error);
					if (seen.busy_res !== want.busy_res)
						report("busy_res", seen.busy_res, want.busy_res);
				end
			end
		end
	end

endmodule

>>> single_wire_sensor_reader.f
rtl/core/swsr_pkg.sv
rtl/core/swsr_cfg.sv
rtl/core/swsr_core.sv
rtl/core/single_wire_sensor_reader.sv
sim/single_wire_sensor_reader_test.sv
